/* hw/rtl/tse_pkg.sv */
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants of the touch sample to event block
// Register indexes, event codes, datapath widths and the words passed
// between the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

  // Width of every raw converter field and every configuration register.
  localparam int RAW_W = 12;

  // Output field widths.
  localparam int EVENT_W = 3;
  localparam int POINT_W = 16;
  localparam int OHMS_W  = 13;

  // Shared multiplier: 25-bit signed by 13-bit signed.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 13;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Shared divider: dividend bits, two quotient bits per cycle.
  localparam int DIV_W      = 28;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_CAL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_CAL_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MAX_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MAX_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLATE_OHMS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OHMS_LIMIT   = 3'd7;

  // Register reset values.
  localparam logic [RAW_W-1:0] RST_X_CAL_MIN    = 12'd0;
  localparam logic [RAW_W-1:0] RST_X_CAL_MAX    = 12'd4095;
  localparam logic [RAW_W-1:0] RST_Y_CAL_MIN    = 12'd0;
  localparam logic [RAW_W-1:0] RST_Y_CAL_MAX    = 12'd4095;
  localparam logic [RAW_W-1:0] RST_SCREEN_MAX_X = 12'd319;
  localparam logic [RAW_W-1:0] RST_SCREEN_MAX_Y = 12'd239;
  localparam logic [RAW_W-1:0] RST_PLATE_OHMS   = 12'd400;
  localparam logic [RAW_W-1:0] RST_OHMS_LIMIT   = 12'd1000;

  // Event codes.
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_MOVE    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_STILL   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd4;

  // Marker for no touch on a coordinate.
  localparam logic [POINT_W-1:0] NO_POINT = 16'hFFFF;

  typedef struct packed {
    logic [RAW_W-1:0] x_cal_min;
    logic [RAW_W-1:0] x_cal_max;
    logic [RAW_W-1:0] y_cal_min;
    logic [RAW_W-1:0] y_cal_max;
    logic [RAW_W-1:0] screen_max_x;
    logic [RAW_W-1:0] screen_max_y;
    logic [RAW_W-1:0] plate_ohms;
    logic [RAW_W-1:0] touch_ohms_limit;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] z1;
    logic [RAW_W-1:0] z2;
    logic [RAW_W-1:0] x;
    logic [RAW_W-1:0] y;
  } sample_t;

  typedef struct packed {
    logic [POINT_W-1:0] px;
    logic [POINT_W-1:0] py;
    logic [OHMS_W-1:0]  ohms;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/tse_div.sv */
// ----------------------------------------------------------------------------
// tse_div: shared iterative unsigned divider
// Restoring division of a DIV_W-bit dividend by a 12-bit divisor, two
// quotient bits per cycle. Quotient bits shift into the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [tse_pkg::DIV_W-1:0]         dividend,
  input  wire logic [tse_pkg::RAW_W-1:0]         divisor,
  output logic                                   done,
  output logic [tse_pkg::DIV_W-1:0]              quotient
);

  localparam int DW = tse_pkg::DIV_W;
  localparam int RW = tse_pkg::RAW_W;

  logic [DW-1:0]                 dvd;
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 dvs;
  logic [tse_pkg::DIV_CNT_W-1:0] cnt;
  logic                          run;
  logic [RW:0]                   step1;
  logic [RW:0]                   step2;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic b,
                                           input logic [RW-1:0] d);
    logic [RW+1:0] diff;
    diff = {1'b0, r, b} - {2'b00, d};
    if (!diff[RW+1]) begin
      div_step = {1'b1, diff[RW-1:0]};
    end else begin
      div_step = {1'b0, r[RW-2:0], b};
    end
  endfunction

  // Two dependent steps per cycle.
  always_comb begin
    step1 = div_step(rem, dvd[DW-1], dvs);
    step2 = div_step(step1[RW-1:0], dvd[DW-2], dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == tse_pkg::DIV_CNT_W'(tse_pkg::DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[DW-3:0], step1[RW], step2[RW]};
      rem <= step2[RW-1:0];
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

/* hw/rtl/tse_core.sv */
// ----------------------------------------------------------------------------
// tse_core: sequencer and shared datapath for one touch sample
// Computes touch resistance and both mapped screen coordinates with one
// shared multiplier and one shared divider, then holds the result word
// until the top level takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_core #(
  parameter int ADC_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire tse_pkg::sample_t sample,
  input  wire tse_pkg::cfg_t    cfg,
  output logic                  idle,
  output logic                  res_valid,
  input  wire logic             res_take,
  output tse_pkg::result_t      res
);

  localparam int RW  = tse_pkg::RAW_W;
  localparam int PW  = tse_pkg::PROD_W;
  localparam int DW  = tse_pkg::DIV_W;
  localparam int PTW = tse_pkg::POINT_W;
  localparam int OW  = tse_pkg::OHMS_W;

  // Converter bits actually used from each field.
  localparam int USE_W = (ADC_BITS < RW) ? ADC_BITS : RW;
  localparam logic [RW-1:0] RAW_MASK = {RW{1'b1}} >> (RW - USE_W);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL_PX   = 4'd1;
  localparam logic [3:0] ST_MUL_NUM  = 4'd2;
  localparam logic [3:0] ST_DIV_OHM  = 4'd3;
  localparam logic [3:0] ST_WAIT_OHM = 4'd4;
  localparam logic [3:0] ST_MUL_X    = 4'd5;
  localparam logic [3:0] ST_DIV_X    = 4'd6;
  localparam logic [3:0] ST_WAIT_X   = 4'd7;
  localparam logic [3:0] ST_MUL_Y    = 4'd8;
  localparam logic [3:0] ST_DIV_Y    = 4'd9;
  localparam logic [3:0] ST_WAIT_Y   = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0]     state;
  logic [3:0]     state_next;

  tse_pkg::sample_t smp;
  logic           pen_down;

  logic signed [tse_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tse_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               mul_p;
  logic signed [PW-1:0]               prod;
  logic [PW-1:0]                      prod_mag;
  logic [PW-1:0]                      prod_shr;

  logic           axis_y;
  logic [RW-1:0]  ax_raw;
  logic [RW-1:0]  ax_min;
  logic [RW-1:0]  ax_max;
  logic [RW-1:0]  ax_smax;
  logic [RW:0]    span;
  logic [RW-1:0]  span_mag;
  logic [RW:0]    offs;

  logic           div_start;
  logic [DW-1:0]  div_dividend;
  logic [RW-1:0]  div_divisor;
  logic           div_done;
  logic [DW-1:0]  div_quot;
  logic           div_neg;
  logic           axis_ok;

  logic [PTW-1:0] q_signed;
  logic [PTW-1:0] map_val;
  logic           map_ok;

  logic           ohm_ok;
  logic [OW-1:0]  ohm_val;
  logic [PTW-1:0] res_x;
  logic [PTW-1:0] res_y;
  logic           ok_x;
  logic           ok_y;
  logic           point_ok;

  // Axis selection shared by both coordinate passes.
  always_comb begin
    axis_y  = (state == ST_MUL_Y) || (state == ST_DIV_Y) || (state == ST_WAIT_Y);
    ax_raw  = axis_y ? smp.y : smp.x;
    ax_min  = axis_y ? cfg.y_cal_min : cfg.x_cal_min;
    ax_max  = axis_y ? cfg.y_cal_max : cfg.x_cal_max;
    ax_smax = axis_y ? cfg.screen_max_y : cfg.screen_max_x;
    span    = {1'b0, ax_max} - {1'b0, ax_min};
    span_mag = span[RW] ? RW'(-span) : span[RW-1:0];
    offs    = {1'b0, ax_raw} - {1'b0, ax_min};
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      ST_MUL_PX: begin
        mul_a = tse_pkg::MUL_A_W'({1'b0, cfg.plate_ohms});
        mul_b = tse_pkg::MUL_B_W'({1'b0, smp.x});
      end
      ST_MUL_NUM: begin
        mul_a = prod[tse_pkg::MUL_A_W-1:0];
        mul_b = {1'b0, smp.z2} - {1'b0, smp.z1};
      end
      default: begin
        mul_a = tse_pkg::MUL_A_W'({1'b0, ax_smax});
        mul_b = offs;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Magnitude of the product, and the resistance dividend with the
  // converter full scale already divided out.
  always_comb begin
    prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    prod_shr = prod_mag >> ADC_BITS;
  end

  // Divider launch.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_mag[DW-1:0];
    div_divisor  = span_mag;
    case (state)
      ST_DIV_OHM: begin
        div_start    = 1'b1;
        div_dividend = prod_shr[DW-1:0];
        div_divisor  = smp.z1;
      end
      ST_DIV_X, ST_DIV_Y: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  tse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Coordinate map: max minus the signed quotient, wrapped to 16 bits.
  always_comb begin
    q_signed = div_neg ? PTW'(-div_quot[PTW-1:0]) : div_quot[PTW-1:0];
    map_val  = PTW'({1'b0, ax_smax}) - q_signed;
    map_ok   = axis_ok && (map_val != tse_pkg::NO_POINT);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_MUL_PX;
      ST_MUL_PX:   state_next = ST_MUL_NUM;
      ST_MUL_NUM:  state_next = ST_DIV_OHM;
      ST_DIV_OHM:  state_next = ST_WAIT_OHM;
      ST_WAIT_OHM: if (div_done) state_next = ST_MUL_X;
      ST_MUL_X:    state_next = ST_DIV_X;
      ST_DIV_X:    state_next = ST_WAIT_X;
      ST_WAIT_X:   if (div_done) state_next = ST_MUL_Y;
      ST_MUL_Y:    state_next = ST_DIV_Y;
      ST_DIV_Y:    state_next = ST_WAIT_Y;
      ST_WAIT_Y:   if (div_done) state_next = ST_DONE;
      ST_DONE:     if (res_take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          smp.z1   <= sample.z1 & RAW_MASK;
          smp.z2   <= sample.z2 & RAW_MASK;
          smp.x    <= sample.x & RAW_MASK;
          smp.y    <= sample.y & RAW_MASK;
          pen_down <= (sample.z1 & RAW_MASK) != '0;
        end
      end
      ST_MUL_PX, ST_MUL_NUM, ST_MUL_X, ST_MUL_Y: begin
        prod <= mul_p;
      end
      ST_DIV_OHM: begin
        div_neg <= prod[PW-1];
      end
      ST_DIV_X, ST_DIV_Y: begin
        div_neg <= prod[PW-1] ^ span[RW];
        axis_ok <= span != '0;
      end
      ST_WAIT_OHM: begin
        if (div_done) begin
          if (!pen_down) begin
            ohm_ok  <= 1'b0;
            ohm_val <= '1;
          end else if (div_neg) begin
            ohm_ok  <= 1'b1;
            ohm_val <= OW'(-div_quot[OW-1:0]);
          end else if (div_quot < DW'(cfg.touch_ohms_limit)) begin
            ohm_ok  <= 1'b1;
            ohm_val <= div_quot[OW-1:0];
          end else begin
            ohm_ok  <= 1'b0;
            ohm_val <= '1;
          end
        end
      end
      ST_WAIT_X: begin
        if (div_done) begin
          res_x <= map_val;
          ok_x  <= map_ok;
        end
      end
      ST_WAIT_Y: begin
        if (div_done) begin
          res_y <= map_val;
          ok_y  <= map_ok;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word: a point only when the sample and both axes are good.
  always_comb begin
    point_ok  = ohm_ok && ok_x && ok_y;
    res.px    = point_ok ? res_x : tse_pkg::NO_POINT;
    res.py    = point_ok ? res_y : tse_pkg::NO_POINT;
    res.ohms  = ohm_val;
    res_valid = (state == ST_DONE);
    idle      = (state == ST_IDLE);
  end

endmodule

`default_nettype wire

/* hw/rtl/touch_sample_to_event_top.sv */
// ----------------------------------------------------------------------------
// touch_sample_to_event_top: resistive touch sample to touch event
// Configuration registers, handshakes, previous-point tracking and the
// output register around the sequenced arithmetic core.
// ----------------------------------------------------------------------------
// One raw sample (z1, z2, x, y) in gives one event word out. Multiplies in
// the states ST_MUL_PX and ST_MUL_NUM form the resistance numerator. The
// shared divider, which retires two quotient bits per cycle, then runs
// three divisions (touch resistance, then x, then y), each a launch,
// DIV_STEPS iterations and a finish. A multiply comes before each
// coordinate division. in_ready is high only while the core is idle; a
// finished word waits in the core until the output register can take it,
// so the next sample is taken once the word has moved there and the core
// has stepped back to idle. Configuration writes apply at once and must be
// made while no sample is in flight.
`default_nettype none

module touch_sample_to_event_top #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Sample channel.
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tse_pkg::RAW_W-1:0]           z1_raw,
  input  wire logic [tse_pkg::RAW_W-1:0]           z2_raw,
  input  wire logic [tse_pkg::RAW_W-1:0]           x_raw,
  input  wire logic [tse_pkg::RAW_W-1:0]           y_raw,
  // Event channel.
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tse_pkg::EVENT_W-1:0]              touch_event,
  output logic signed [tse_pkg::POINT_W-1:0]       point_x,
  output logic signed [tse_pkg::POINT_W-1:0]       point_y,
  output logic signed [tse_pkg::OHMS_W-1:0]        touch_ohms,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [tse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tse_pkg::RAW_W-1:0]           cfg_data
);

  localparam int PTW = tse_pkg::POINT_W;

  tse_pkg::cfg_t    cfg;
  tse_pkg::sample_t sample;
  tse_pkg::result_t res;
  logic             core_idle;
  logic             res_valid;
  logic             res_take;
  logic             start;

  logic [PTW-1:0]   last_x;
  logic [PTW-1:0]   last_y;
  logic [tse_pkg::EVENT_W-1:0] ev_next;
  logic [PTW-1:0]   px_next;
  logic [PTW-1:0]   py_next;
  logic             upd_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_cal_min        <= tse_pkg::RST_X_CAL_MIN;
      cfg.x_cal_max        <= tse_pkg::RST_X_CAL_MAX;
      cfg.y_cal_min        <= tse_pkg::RST_Y_CAL_MIN;
      cfg.y_cal_max        <= tse_pkg::RST_Y_CAL_MAX;
      cfg.screen_max_x     <= tse_pkg::RST_SCREEN_MAX_X;
      cfg.screen_max_y     <= tse_pkg::RST_SCREEN_MAX_Y;
      cfg.plate_ohms       <= tse_pkg::RST_PLATE_OHMS;
      cfg.touch_ohms_limit <= tse_pkg::RST_OHMS_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        tse_pkg::REG_X_CAL_MIN:    cfg.x_cal_min        <= cfg_data;
        tse_pkg::REG_X_CAL_MAX:    cfg.x_cal_max        <= cfg_data;
        tse_pkg::REG_Y_CAL_MIN:    cfg.y_cal_min        <= cfg_data;
        tse_pkg::REG_Y_CAL_MAX:    cfg.y_cal_max        <= cfg_data;
        tse_pkg::REG_SCREEN_MAX_X: cfg.screen_max_x     <= cfg_data;
        tse_pkg::REG_SCREEN_MAX_Y: cfg.screen_max_y     <= cfg_data;
        tse_pkg::REG_PLATE_OHMS:   cfg.plate_ohms       <= cfg_data;
        tse_pkg::REG_OHMS_LIMIT:   cfg.touch_ohms_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sample handshake.
  assign in_ready  = core_idle;
  assign start     = in_valid && in_ready;
  assign sample.z1 = z1_raw;
  assign sample.z2 = z2_raw;
  assign sample.x  = x_raw;
  assign sample.y  = y_raw;

  tse_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (sample),
    .cfg       (cfg),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // The core word moves on when the output register is free or emptying.
  assign res_take = res_valid && (!out_valid || out_ready);

  // Event classification against the previous point.
  always_comb begin
    px_next  = res.px;
    py_next  = res.py;
    upd_last = 1'b1;
    if ((last_x == res.px) && (last_y == res.py)) begin
      ev_next  = tse_pkg::EV_STILL;
      upd_last = 1'b0;
    end else if ((last_x != tse_pkg::NO_POINT) || (last_y != tse_pkg::NO_POINT)) begin
      if (res.px != tse_pkg::NO_POINT) begin
        ev_next = tse_pkg::EV_MOVE;
      end else begin
        ev_next = tse_pkg::EV_RELEASE;
        px_next = last_x;
        py_next = last_y;
      end
    end else begin
      ev_next = (res.px != tse_pkg::NO_POINT) ? tse_pkg::EV_PRESS : tse_pkg::EV_NONE;
    end
  end

  // Previous point.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= tse_pkg::NO_POINT;
      last_y <= tse_pkg::NO_POINT;
    end else if (res_take && upd_last) begin
      last_x <= res.px;
      last_y <= res.py;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      touch_event <= ev_next;
      point_x     <= $signed(px_next);
      point_y     <= $signed(py_next);
      touch_ohms  <= $signed(res.ohms);
    end
  end

endmodule

`default_nettype wire
